// ===== rtl/core/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared codes, widths and helpers of the MIDI file stream parser.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int unsigned OffsetBitsDefault = 32;

  localparam logic [4:0] PH_HID    = 5'd0;
  localparam logic [4:0] PH_HLEN   = 5'd1;
  localparam logic [4:0] PH_HBODY  = 5'd2;
  localparam logic [4:0] PH_TID    = 5'd3;
  localparam logic [4:0] PH_TLEN   = 5'd4;
  localparam logic [4:0] PH_DELTA  = 5'd5;
  localparam logic [4:0] PH_STATUS = 5'd6;
  localparam logic [4:0] PH_MTYPE  = 5'd7;
  localparam logic [4:0] PH_MLEN   = 5'd8;
  localparam logic [4:0] PH_TEMPO  = 5'd9;
  localparam logic [4:0] PH_SKIP   = 5'd10;
  localparam logic [4:0] PH_XLEN   = 5'd11;
  localparam logic [4:0] PH_D1     = 5'd12;
  localparam logic [4:0] PH_D2     = 5'd13;
  localparam logic [4:0] PH_DRAIN  = 5'd14;
  localparam logic [4:0] PH_TAIL   = 5'd15;
  localparam logic [4:0] PH_IGNORE = 5'd16;

  typedef enum logic [1:0] {
    KIND_EVENT  = 2'd0,
    KIND_TEMPO  = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    ERR_HEAD_ID     = 5'd0,
    ERR_HEAD_LEN    = 5'd1,
    ERR_HEAD_BODY   = 5'd2,
    ERR_FORMAT      = 5'd3,
    ERR_DIVISION    = 5'd4,
    ERR_TRACK_CHUNK = 5'd5,
    ERR_DELTA_VLQ   = 5'd6,
    ERR_TICK_OVF    = 5'd7,
    ERR_NO_STATUS   = 5'd8,
    ERR_NO_RUNNING  = 5'd9,
    ERR_META_TRUNC  = 5'd10,
    ERR_EOT_LEN     = 5'd11,
    ERR_AFTER_EOT   = 5'd12,
    ERR_TEMPO_LEN   = 5'd13,
    ERR_TEMPO_ZERO  = 5'd14,
    ERR_SEQ_OVF     = 5'd15,
    ERR_SYSEX_TRUNC = 5'd16,
    ERR_SYSTEM      = 5'd17,
    ERR_CHAN_TRUNC  = 5'd18,
    ERR_DATA_BIT7   = 5'd19,
    ERR_NO_EOT      = 5'd20,
    ERR_TRAILING    = 5'd21
  } err_e;

  localparam logic [7:0] META_EOT   = 8'h2f;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] ST_SYSEX   = 8'hf0;
  localparam logic [7:0] ST_ESCAPE  = 8'hf7;
  localparam logic [7:0] ST_META    = 8'hff;
  localparam logic [7:0] ST_SYSTEM  = 8'hf0;
  localparam logic [3:0] TYPE_PROG  = 4'hc;
  localparam logic [3:0] TYPE_PRESS = 4'hd;
  localparam logic [3:0] TYPE_CTRL  = 4'hb;

  localparam int unsigned OutDataBits = 216;

  typedef struct packed {
    logic [31:0] error_offset;
    logic [4:0]  error_code;
    logic [14:0] time_division;
    logic [15:0] track_count;
    logic        file_format;
    logic [23:0] tempo_value;
    logic [6:0]  data_two;
    logic [6:0]  data_one;
    logic [7:0]  status_code;
    logic [31:0] order;
    logic [63:0] tick;
    kind_e       kind;
  } res_t;

  function automatic logic [7:0] tag_byte(input logic is_trk, input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = 8'h4d;
      2'd1:    r = 8'h54;
      2'd2:    r = is_trk ? 8'h72 : 8'h68;
      default: r = is_trk ? 8'h6b : 8'h64;
    endcase
    return r;
  endfunction

  function automatic res_t mk_err(input err_e code, input logic [31:0] offset);
    res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    r.error_offset = offset;
    return r;
  endfunction

endpackage

// ===== rtl/core/midi_file_stream_parser.sv =====
// ----------------------------------------------------------------------------
// midi_file_stream_parser
// Checks a Standard MIDI File byte by byte and streams out its events.
// ----------------------------------------------------------------------------
// The slave stream takes one file byte per request in tdata, with tlast on
// the final byte of a file; the next byte starts a new file. The master
// stream returns channel events, tempo changes and one final accept or error
// result per file, in file order, with the result kind in tuser. Bytes that
// produce nothing are absorbed without a result.
// Each byte is decoded in the cycle it is accepted and its result appears in
// the output register on the next cycle, so one byte is taken every cycle while
// the receiver keeps up. A stalled result holds the output register, and the
// slave side stalls only while that register is full and not being taken.
// Reset clears the parser to the start of a file, empties the output register
// and sets the channel filter mask to all ones. The configuration channel is
// always ready; the user must write it only while the stream is idle, and the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module midi_file_stream_parser
  import msp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // data_byte
  input  logic                   s_axis_tlast_i,   // last_byte
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tick, order, status_code, data_one, data_two, tempo_value, file_format,
  // track_count, time_division, error_code, error_offset, then zero fill
  output logic [OutDataBits-1:0] m_axis_tdata_o,
  output logic [1:0]             m_axis_tuser_o,   // kind
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [15:0]            cfg_data_i        // chan_filter
);

  logic [15:0]            mask_q;
  logic [4:0]             phase_q, phase_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, evs_q, evs_d, pls_q, pls_d;
  logic [OFFSET_BITS-1:0] cks_q, cks_d, poff_q, poff_d;
  logic [31:0]            shift_q, shift_d, chunk_q, chunk_d, pay_q, pay_d;
  logic [31:0]            seq_q, seq_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [63:0]            tick_q, tick_d;
  logic [7:0]             run_q, run_d, cur_q, cur_d, held_q, held_d, meta_q, meta_d;
  logic [23:0]            tempo_q, tempo_d;
  logic [15:0]            trk_q, trk_d;
  logic [47:0]            hdr_q, hdr_d;
  logic                   eot_q, eot_d;
  err_e                   pcode_q, pcode_d;
  logic                   out_vld_q, out_vld_d;
  res_t                   out_q, res;
  logic                   rv, in_acc;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] off, nxt;
    logic [31:0]            sv7, sv8, len;
    logic [2:0]             cv;
    logic [64:0]            sum;
    logic [23:0]            tv;
    logic [7:0]             cs;
    logic                   dn, ov, fin, ftwo, hold1, fail;
    logic [7:0]             fd1, fd2;
    logic [15:0]            hf, ht, hv;
    err_e                   fcode;
    logic [OFFSET_BITS-1:0] foff;
    b = s_axis_tdata_i;
    off = off_q;
    nxt = off_q + 1'b1;
    sv7 = {shift_q[24:0], b[6:0]};
    sv8 = {shift_q[23:0], b};
    cv = cnt_q + 3'd1;
    dn = !b[7];
    ov = b[7] && (cv >= 3'd4);
    len = sv7;
    sum = {1'b0, tick_q} + {33'd0, sv7};
    tv = {tempo_q[15:0], b};
    cs = cur_q;
    fin = 1'b0; ftwo = 1'b0; hold1 = 1'b0; fail = 1'b0;
    fd1 = 8'd0; fd2 = 8'd0;
    fcode = ERR_HEAD_ID; foff = '0;
    hf = 16'd0; ht = 16'd0; hv = 16'd0;
    phase_d = phase_q; off_d = off_q; evs_d = evs_q; pls_d = pls_q; cks_d = cks_q;
    poff_d = poff_q; shift_d = shift_q; chunk_d = chunk_q; pay_d = pay_q;
    seq_d = seq_q; cnt_d = cnt_q; tick_d = tick_q; run_d = run_q; cur_d = cur_q;
    held_d = held_q; meta_d = meta_q; tempo_d = tempo_q; trk_d = trk_q;
    hdr_d = hdr_q; eot_d = eot_q; pcode_d = pcode_q;
    res = '0;
    rv = 1'b0;
    if (in_acc) begin
      off_d = nxt;
      unique case (phase_q)
        PH_HID: begin
          if (b != tag_byte(1'b0, cnt_q[1:0])) begin
            res = mk_err(ERR_HEAD_ID, 32'd0); rv = 1'b1; phase_d = PH_IGNORE;
          end else begin
            cnt_d = cv;
            if (cv == 3'd4) begin
              phase_d = PH_HLEN; cnt_d = '0; shift_d = '0;
            end
          end
        end
        PH_HLEN: begin
          shift_d = sv8; cnt_d = cv;
          if (cv == 3'd4) begin
            if (sv8 < 32'd6) begin
              res = mk_err(ERR_HEAD_LEN, 32'd4); rv = 1'b1; phase_d = PH_IGNORE;
            end else begin
              chunk_d = sv8; cnt_d = '0; hdr_d = '0; phase_d = PH_HBODY;
            end
          end
        end
        PH_HBODY: begin
          if (cnt_q < 3'd6) begin
            hdr_d = {hdr_q[39:0], b}; cnt_d = cv;
          end
          chunk_d = chunk_q - 32'(chunk_q != 32'd0);
          if (chunk_d == 32'd0) begin
            hf = hdr_d[47:32]; ht = hdr_d[31:16]; hv = hdr_d[15:0];
            if (hf > 16'd1 || ht == 16'd0 || (hf == 16'd0 && ht != 16'd1)) begin
              res = mk_err(ERR_FORMAT, 32'd8); rv = 1'b1; phase_d = PH_IGNORE;
            end else if (hv == 16'd0 || hv[15]) begin
              res = mk_err(ERR_DIVISION, 32'd12); rv = 1'b1; phase_d = PH_IGNORE;
            end else begin
              trk_d = ht; phase_d = PH_TID; cnt_d = '0; cks_d = nxt;
            end
          end
        end
        PH_TID: begin
          if (b != tag_byte(1'b1, cnt_q[1:0])) begin
            res = mk_err(ERR_TRACK_CHUNK, 32'(cks_q)); rv = 1'b1; phase_d = PH_IGNORE;
          end else begin
            cnt_d = cv;
            if (cv == 3'd4) begin
              phase_d = PH_TLEN; cnt_d = '0; shift_d = '0;
            end
          end
        end
        PH_TLEN: begin
          shift_d = sv8; cnt_d = cv;
          if (cv == 3'd4) begin
            chunk_d = sv8; tick_d = '0; run_d = '0; eot_d = 1'b0;
            phase_d = PH_DELTA; cnt_d = '0; shift_d = '0;
            if (sv8 == 32'd0) begin
              res = mk_err(ERR_NO_EOT, 32'(nxt)); rv = 1'b1; phase_d = PH_IGNORE;
            end
          end
        end
        PH_TAIL: begin
          res = mk_err(ERR_TRAILING, 32'(off)); rv = 1'b1; phase_d = PH_IGNORE;
        end
        PH_IGNORE: begin
        end
        default: begin
          chunk_d = chunk_q - 32'(chunk_q != 32'd0);
          unique case (phase_q)
            PH_DELTA: begin
              if (cnt_q == 3'd0) evs_d = off;
              shift_d = sv7; cnt_d = cv;
              if (ov) begin
                fail = 1'b1; fcode = ERR_DELTA_VLQ; foff = evs_d;
              end else if (dn) begin
                if (sum[64]) begin
                  fail = 1'b1; fcode = ERR_TICK_OVF; foff = evs_d;
                end else begin
                  tick_d = sum[63:0]; phase_d = PH_STATUS;
                end
              end
            end
            PH_STATUS: begin
              if (b[7]) begin
                cur_d = b;
                run_d = (b < ST_SYSTEM) ? b : 8'd0;
                if (b == ST_META) begin
                  phase_d = PH_MTYPE;
                end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                  phase_d = PH_XLEN; cnt_d = '0; shift_d = '0;
                end else if (b >= ST_SYSTEM) begin
                  fail = 1'b1; fcode = ERR_SYSTEM; foff = evs_q;
                end else begin
                  phase_d = PH_D1;
                end
              end else if (run_q == 8'd0) begin
                fail = 1'b1; fcode = ERR_NO_RUNNING; foff = off;
              end else begin
                cur_d = run_q; cs = run_q; hold1 = 1'b1;
              end
            end
            PH_MTYPE: begin
              meta_d = b; phase_d = PH_MLEN; cnt_d = '0; shift_d = '0;
            end
            PH_MLEN: begin
              shift_d = sv7; cnt_d = cv;
              if (ov) begin
                fail = 1'b1; fcode = ERR_META_TRUNC; foff = evs_q;
              end else if (dn) begin
                if (len > chunk_d) begin
                  fail = 1'b1; fcode = ERR_META_TRUNC; foff = evs_q;
                end else begin
                  pls_d = nxt;
                  if (meta_q == META_EOT) begin
                    if (len != 32'd0) begin
                      fail = 1'b1; fcode = ERR_EOT_LEN; foff = nxt;
                    end else if (chunk_d != 32'd0) begin
                      fail = 1'b1; fcode = ERR_AFTER_EOT; foff = nxt;
                    end else begin
                      eot_d = 1'b1; phase_d = PH_DELTA; cnt_d = '0; shift_d = '0;
                    end
                  end else if (meta_q == META_TEMPO) begin
                    if (len != 32'd3) begin
                      fail = 1'b1; fcode = ERR_TEMPO_LEN; foff = nxt;
                    end else begin
                      tempo_d = '0; cnt_d = '0; phase_d = PH_TEMPO;
                    end
                  end else begin
                    pay_d = len;
                    if (len == 32'd0) begin
                      phase_d = PH_DELTA; cnt_d = '0; shift_d = '0;
                    end else begin
                      phase_d = PH_SKIP;
                    end
                  end
                end
              end
            end
            PH_TEMPO: begin
              tempo_d = tv; cnt_d = cv;
              if (cv == 3'd3) begin
                if (tv == 24'd0) begin
                  fail = 1'b1; fcode = ERR_TEMPO_ZERO; foff = pls_q;
                end else if (seq_q == 32'hffff_ffff) begin
                  fail = 1'b1; fcode = ERR_SEQ_OVF; foff = evs_q;
                end else begin
                  res.kind = KIND_TEMPO; res.tick = tick_q; res.order = seq_q;
                  res.tempo_value = tv; rv = 1'b1;
                  seq_d = seq_q + 32'd1;
                  phase_d = PH_DELTA; cnt_d = '0; shift_d = '0;
                end
              end
            end
            PH_SKIP: begin
              pay_d = pay_q - 32'(pay_q != 32'd0);
              if (pay_d == 32'd0) begin
                phase_d = PH_DELTA; cnt_d = '0; shift_d = '0;
              end
            end
            PH_XLEN: begin
              shift_d = sv7; cnt_d = cv;
              if (ov || (dn && sv7 > chunk_d)) begin
                fail = 1'b1; fcode = ERR_SYSEX_TRUNC; foff = evs_q;
              end else if (dn) begin
                pay_d = sv7;
                if (sv7 == 32'd0) begin
                  phase_d = PH_DELTA; cnt_d = '0; shift_d = '0;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
            end
            PH_D1: hold1 = 1'b1;
            PH_D2: begin
              fin = 1'b1; ftwo = 1'b1; fd1 = held_q; fd2 = b;
            end
            default: begin
            end
          endcase
          if (hold1) begin
            if (cs[7:4] == TYPE_PROG || cs[7:4] == TYPE_PRESS) begin
              fin = 1'b1; fd1 = b;
            end else begin
              held_d = b; phase_d = PH_D2;
            end
          end
          if (fin) begin
            if (fd1[7] || (ftwo && fd2[7])) begin
              fail = 1'b1; fcode = ERR_DATA_BIT7; foff = evs_q;
            end else if (cs[7:4] <= TYPE_CTRL && mask_q[cs[3:0]]
                         && seq_q == 32'hffff_ffff) begin
              fail = 1'b1; fcode = ERR_SEQ_OVF; foff = evs_q;
            end else begin
              if (cs[7:4] <= TYPE_CTRL && mask_q[cs[3:0]]) begin
                res.kind = KIND_EVENT; res.tick = tick_q; res.order = seq_q;
                res.status_code = cs; res.data_one = fd1[6:0];
                res.data_two = fd2[6:0]; rv = 1'b1;
                seq_d = seq_q + 32'd1;
              end
              phase_d = PH_DELTA; cnt_d = '0; shift_d = '0;
            end
          end
          if (fail) begin
            pcode_d = fcode; poff_d = foff; phase_d = PH_DRAIN;
          end
          if (chunk_d == 32'd0) begin
            rv = 1'b1;
            if (phase_d == PH_DRAIN) begin
              res = mk_err(pcode_d, 32'(poff_d)); phase_d = PH_IGNORE;
            end else if (phase_d == PH_DELTA && cnt_d == 3'd0 && eot_d) begin
              rv = 1'b0;
              trk_d = trk_q - 16'(trk_q != 16'd0);
              if (trk_d == 16'd0) begin
                phase_d = PH_TAIL;
              end else begin
                phase_d = PH_TID; cnt_d = '0; cks_d = nxt;
              end
            end else begin
              if (phase_d == PH_DELTA) begin
                res = (cnt_d != 3'd0) ? mk_err(ERR_DELTA_VLQ, 32'(evs_d))
                                      : mk_err(ERR_NO_EOT, 32'(nxt));
              end else if (phase_d == PH_STATUS) begin
                res = mk_err(ERR_NO_STATUS, 32'(nxt));
              end else if (phase_d == PH_XLEN) begin
                res = mk_err(ERR_SYSEX_TRUNC, 32'(evs_d));
              end else if (phase_d == PH_D1 || phase_d == PH_D2) begin
                res = mk_err(ERR_CHAN_TRUNC, 32'(evs_d));
              end else begin
                res = mk_err(ERR_META_TRUNC, 32'(evs_d));
              end
              phase_d = PH_IGNORE;
            end
          end
        end
      endcase
      if (s_axis_tlast_i) begin
        unique case (phase_d)
          PH_HID, PH_HLEN: begin
            res = mk_err(ERR_HEAD_ID, 32'd0); rv = 1'b1;
          end
          PH_HBODY: begin
            res = mk_err(ERR_HEAD_LEN, 32'd4); rv = 1'b1;
          end
          PH_TAIL: begin
            res = '0; res.kind = KIND_ACCEPT;
            res.file_format = hdr_d[32];
            res.track_count = hdr_d[31:16];
            res.time_division = hdr_d[14:0];
            rv = 1'b1;
          end
          PH_IGNORE: begin
          end
          default: begin
            res = mk_err(ERR_TRACK_CHUNK, 32'(cks_d)); rv = 1'b1;
          end
        endcase
        phase_d = PH_HID; off_d = '0; evs_d = '0; pls_d = '0; cks_d = '0;
        poff_d = '0; shift_d = '0; chunk_d = '0; pay_d = '0; seq_d = '0;
        cnt_d = '0; tick_d = '0; run_d = '0; cur_d = '0; held_d = '0;
        meta_d = '0; tempo_d = '0; trk_d = '0; hdr_d = '0; eot_d = 1'b0;
        pcode_d = ERR_HEAD_ID;
      end
    end
  end

  assign out_vld_d = in_acc ? rv : (out_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 16'hffff;
      phase_q <= PH_HID; off_q <= '0; evs_q <= '0; pls_q <= '0; cks_q <= '0;
      poff_q <= '0; shift_q <= '0; chunk_q <= '0; pay_q <= '0; seq_q <= '0;
      cnt_q <= '0; tick_q <= '0; run_q <= '0; cur_q <= '0; held_q <= '0;
      meta_q <= '0; tempo_q <= '0; trk_q <= '0; hdr_q <= '0; eot_q <= 1'b0;
      pcode_q <= ERR_HEAD_ID; out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) mask_q <= cfg_data_i;
      phase_q <= phase_d; off_q <= off_d; evs_q <= evs_d; pls_q <= pls_d;
      cks_q <= cks_d; poff_q <= poff_d; shift_q <= shift_d; chunk_q <= chunk_d;
      pay_q <= pay_d; seq_q <= seq_d; cnt_q <= cnt_d; tick_q <= tick_d;
      run_q <= run_d; cur_q <= cur_d; held_q <= held_d; meta_q <= meta_d;
      tempo_q <= tempo_d; trk_q <= trk_d; hdr_q <= hdr_d; eot_q <= eot_d;
      pcode_q <= pcode_d; out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && rv) out_q <= res;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o = out_q.kind;
  assign m_axis_tdata_o = {5'd0, out_q.error_offset, out_q.error_code,
                           out_q.time_division, out_q.track_count,
                           out_q.file_format, out_q.tempo_value, out_q.data_two,
                           out_q.data_one, out_q.status_code, out_q.order,
                           out_q.tick};

endmodule
